>>> rtl/core/owm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_pkg
// Types and codes shared by the 1-Wire bus master modules.
// ----------------------------------------------------------------------------
package owm_pkg;

    // request codes carried in req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [2:0] CFG_RESET_RELEASE  = 3'd1;
    localparam logic [2:0] CFG_PRESENCE_OFS   = 3'd2;
    localparam logic [2:0] CFG_W1_LOW         = 3'd3;
    localparam logic [2:0] CFG_W1_HIGH        = 3'd4;
    localparam logic [2:0] CFG_W0_LOW         = 3'd5;
    localparam logic [2:0] CFG_W0_HIGH        = 3'd6;
    localparam logic [2:0] CFG_READ_LOW       = 3'd7;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] write_data;
        logic       bus_level;
    } owm_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } owm_out_t;

    typedef struct packed {
        logic [15:0] reset_low_ticks;
        logic [15:0] reset_release_ticks;
        logic [15:0] presence_sample_offset;
        logic [11:0] write_one_low_ticks;
        logic [11:0] write_one_high_ticks;
        logic [11:0] write_zero_low_ticks;
        logic [11:0] write_zero_high_ticks;
        logic [11:0] read_low_ticks;
    } owm_cfg_t;

endpackage

>>> rtl/core/owm_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Slot timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output owm_cfg_t              cfg
);

    owm_cfg_t cfg_reg;
    owm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:     cfg_next.reset_low_ticks        = cfg_data;
                CFG_RESET_RELEASE: cfg_next.reset_release_ticks    = cfg_data;
                CFG_PRESENCE_OFS:  cfg_next.presence_sample_offset = cfg_data;
                CFG_W1_LOW:        cfg_next.write_one_low_ticks    = cfg_data[11:0];
                CFG_W1_HIGH:       cfg_next.write_one_high_ticks   = cfg_data[11:0];
                CFG_W0_LOW:        cfg_next.write_zero_low_ticks   = cfg_data[11:0];
                CFG_W0_HIGH:       cfg_next.write_zero_high_ticks  = cfg_data[11:0];
                CFG_READ_LOW:      cfg_next.read_low_ticks         = cfg_data[11:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks        <= 16'd3812;
            cfg_reg.reset_release_ticks    <= 16'd3897;
            cfg_reg.presence_sample_offset <= 16'd0;
            cfg_reg.write_one_low_ticks    <= 12'd40;
            cfg_reg.write_one_high_ticks   <= 12'd500;
            cfg_reg.write_zero_low_ticks   <= 12'd470;
            cfg_reg.write_zero_high_ticks  <= 12'd60;
            cfg_reg.read_low_ticks         <= 12'd44;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/owm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_seq
// Slot sequencer: bus reset, byte write and byte read timing, one item
// per cycle while en is high, with the result formed from the updated state.
// ----------------------------------------------------------------------------
module owm_seq
    import owm_pkg::*;
#(
    parameter int READ_SAMPLE_TICKS   = 70,
    parameter int READ_RECOVERY_TICKS = 443
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  owm_in_t  item,
    input  owm_cfg_t cfg,
    output owm_out_t result
);

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_LOW     = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    localparam logic [15:0] RD_SAMPLE = 16'(READ_SAMPLE_TICKS);
    localparam logic [15:0] RD_LEN    = 16'(READ_SAMPLE_TICKS + READ_RECOVERY_TICKS);

    logic [1:0]  phase_reg,     phase_next;
    logic [1:0]  op_reg,        op_next;
    logic [15:0] cnt_reg,       cnt_next;
    logic [2:0]  bit_reg,       bit_next;
    logic [7:0]  shift_reg,     shift_next;
    logic        presence_reg,  presence_next;
    logic [7:0]  last_rd_reg,   last_rd_next;

    logic [15:0] low_len;
    logic [15:0] rel_len;
    logic [15:0] cnt_inc;
    logic [15:0] sample_at;
    logic        done;
    logic        rejected;

    always_comb
    begin
        case (op_reg)
            REQ_RESET: low_len = cfg.reset_low_ticks;
            REQ_WRITE: low_len = shift_reg[0] ? 16'(cfg.write_one_low_ticks)
                                              : 16'(cfg.write_zero_low_ticks);
            default:   low_len = 16'(cfg.read_low_ticks);
        endcase
        case (op_reg)
            REQ_RESET: rel_len = cfg.reset_release_ticks;
            REQ_WRITE: rel_len = shift_reg[0] ? 16'(cfg.write_one_high_ticks)
                                              : 16'(cfg.write_zero_high_ticks);
            default:   rel_len = RD_LEN;
        endcase
    end

    // presence sample index, clamped to the last released tick
    always_comb
    begin
        if (cfg.reset_release_ticks == 16'd0)
            sample_at = 16'd0;
        else if (cfg.presence_sample_offset >= cfg.reset_release_ticks)
            sample_at = cfg.reset_release_ticks - 16'd1;
        else
            sample_at = cfg.presence_sample_offset;
    end

    assign cnt_inc = cnt_reg + 16'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        last_rd_next  = last_rd_reg;
        done          = 1'b0;
        rejected      = 1'b0;

        if (item.req_type == REQ_TICK)
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= low_len)
                    begin
                        phase_next = PH_RELEASE;
                        cnt_next   = 16'd0;
                    end
                end
                PH_RELEASE:
                begin
                    if (op_reg == REQ_RESET && cnt_reg == sample_at)
                        presence_next = !item.bus_level;
                    if (op_reg == REQ_READ && cnt_reg == RD_SAMPLE)
                        shift_next = {item.bus_level, shift_reg[7:1]};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= rel_len)
                    begin
                        cnt_next = 16'd0;
                        if (op_reg == REQ_RESET)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            if (op_reg == REQ_WRITE)
                                shift_next = {1'b0, shift_reg[7:1]};
                            if (bit_reg == 3'd7)
                            begin
                                bit_next   = 3'd0;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                                if (op_reg == REQ_READ)
                                    last_rd_next = shift_next;
                            end
                            else
                            begin
                                bit_next   = bit_reg + 3'd1;
                                phase_next = PH_LOW;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        else if (phase_reg != PH_IDLE)
        begin
            rejected = 1'b1;
        end
        else
        begin
            op_next    = item.req_type;
            phase_next = PH_LOW;
            cnt_next   = 16'd0;
            bit_next   = 3'd0;
            if (item.req_type == REQ_RESET)
                presence_next = 1'b0;
            shift_next = (item.req_type == REQ_WRITE) ? item.write_data : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            op_reg       <= REQ_TICK;
            cnt_reg      <= 16'd0;
            bit_reg      <= 3'd0;
            shift_reg    <= 8'd0;
            presence_reg <= 1'b0;
            last_rd_reg  <= 8'd0;
        end
        else if (en)
        begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            last_rd_reg  <= last_rd_next;
        end
    end

    always_comb
    begin
        result.drive_low = (phase_next == PH_LOW);
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.presence  = presence_next;
        result.read_data = last_rd_next;
        result.rejected  = rejected;
    end

endmodule

>>> rtl/core/one_wire_bus_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Timed 1-Wire master: bus reset, byte write and byte read slots driven by
// tick items that carry the sampled line level.
//
// Request channel (req_valid / req_stall / req_item): each item is a tick or
// a command (bus reset, write byte, read byte). Result channel (res_valid /
// res_stall / res_item): exactly one result per item, in order, giving the
// line drive, busy, done, presence, last read byte and a reject flag for a
// command that arrived while a sequence was running.
// An accepted item lands in the input register; the sequencer updates its
// state and writes the result register from it. One item per cycle is
// sustained while the receiver does not stall, with the sequencer update
// between the two registers.
// When the receiver stalls the result holds, the input register keeps the
// next item and req_stall rises only while both registers are full. Reset
// empties both registers, idles the sequencer and loads the timing registers
// with their default values. The user must write them through cfg_we /
// cfg_index / cfg_data only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int READ_SAMPLE_TICKS   = 70,
    parameter int READ_RECOVERY_TICKS = 443
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  owm_in_t               req_item,
    output logic                  res_valid,
    input  logic                  res_stall,
    output owm_out_t              res_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    owm_cfg_t cfg;
    owm_in_t  in_item_reg;
    logic     in_valid_reg;
    owm_out_t res_item_reg;
    logic     res_valid_reg;
    owm_out_t seq_result;
    logic     pipe_adv;
    logic     seq_en;

    assign pipe_adv  = !res_valid_reg || !res_stall;
    assign seq_en    = in_valid_reg && pipe_adv;
    assign req_stall = in_valid_reg && !pipe_adv;

    owm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owm_seq #(
        .READ_SAMPLE_TICKS   (READ_SAMPLE_TICKS),
        .READ_RECOVERY_TICKS (READ_RECOVERY_TICKS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (seq_en),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                in_valid_reg <= req_valid;
            if (pipe_adv)
                res_valid_reg <= in_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
            in_item_reg <= req_item;
        if (seq_en)
            res_item_reg <= seq_result;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

endmodule

>>> rtl/core/owm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owm_checker
// Port-level checks on the result channel of the 1-Wire master.
// ----------------------------------------------------------------------------
module owm_checker
    import owm_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     res_valid,
    input logic     res_stall,
    input owm_out_t res_item
);

    // a stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    // a completed sequence leaves the master idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> !res_item.busy_res && !res_item.drive_low)
        else $error("done reported while still busy");

    // the line is only pulled low inside a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.drive_low |-> res_item.busy_res)
        else $error("line driven low while idle");

    // a rejected command means a sequence was running and still runs
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.rejected |-> res_item.busy_res && !res_item.done_res)
        else $error("command rejected while idle");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

>>> tb/one_wire_bus_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Self-checking bench for the timed 1-Wire master. A scoreboard class keeps
// its own copy of the slot sequencer and the timing registers and predicts
// the result of every accepted item. Results are compared field by field in
// order. Stimulus runs directed sequences on the default timing with
// mid-sequence retiming, on zero-length registers and a full byte read,
// then randomized resets and byte writes with stray commands, idle ticks
// and random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;
    import owm_pkg::*;

    localparam int READ_SAMPLE_TICKS   = 70;
    localparam int READ_RECOVERY_TICKS = 443;
    localparam int RESET_CYCLES        = 8;
    localparam int TAIL_CYCLES         = 20;
    localparam int RANDOM_PHASES       = 4;
    localparam int SEQS_PER_PHASE      = 8;
    localparam int MAX_GAP             = 11;
    localparam int MAX_REPORTS         = 200;
    // bound on the run, well above the slowest correct run (all gaps and stalls at max)
    localparam int LIMIT_CYCLES        = 1_000_000;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_LOW, SEQ_RELEASE} seq_phase_t;
    typedef enum int {LVL_RANDOM, LVL_HIGH, LVL_LOW} level_mode_t;

    class owm_scoreboard;
        logic [15:0] rst_low_len;
        logic [15:0] rst_rel_len;
        logic [15:0] pres_ofs;
        logic [11:0] w1_low_len;
        logic [11:0] w1_rel_len;
        logic [11:0] w0_low_len;
        logic [11:0] w0_rel_len;
        logic [11:0] rd_low_len;

        seq_phase_t  ph;
        logic [1:0]  op;
        logic [15:0] tick_cnt;
        logic [2:0]  bit_no;
        logic [7:0]  shreg;
        logic        pres;
        logic [7:0]  rd_byte;

        owm_out_t    want_q[$];
        int          errors;
        int          checked;
        int          resets_done;
        int          writes_done;
        int          reads_done;
        int          rejects_seen;

        function new();
            rst_low_len  = 16'd3812;
            rst_rel_len  = 16'd3897;
            pres_ofs     = 16'd0;
            w1_low_len   = 12'd40;
            w1_rel_len   = 12'd500;
            w0_low_len   = 12'd470;
            w0_rel_len   = 12'd60;
            rd_low_len   = 12'd44;
            ph           = SEQ_IDLE;
            op           = REQ_TICK;
            tick_cnt     = '0;
            bit_no       = '0;
            shreg        = '0;
            pres         = 1'b0;
            rd_byte      = '0;
            errors       = 0;
            checked      = 0;
            resets_done  = 0;
            writes_done  = 0;
            reads_done   = 0;
            rejects_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_RESET_LOW:     rst_low_len = val;
                CFG_RESET_RELEASE: rst_rel_len = val;
                CFG_PRESENCE_OFS:  pres_ofs    = val;
                CFG_W1_LOW:        w1_low_len  = val[11:0];
                CFG_W1_HIGH:       w1_rel_len  = val[11:0];
                CFG_W0_LOW:        w0_low_len  = val[11:0];
                CFG_W0_HIGH:       w0_rel_len  = val[11:0];
                default:           rd_low_len  = val[11:0];
            endcase
        endfunction

        function logic [15:0] low_len();
            if (op == REQ_RESET)
                return rst_low_len;
            if (op == REQ_WRITE)
                return shreg[0] ? {4'd0, w1_low_len} : {4'd0, w0_low_len};
            return {4'd0, rd_low_len};
        endfunction

        function logic [15:0] rel_len();
            if (op == REQ_RESET)
                return rst_rel_len;
            if (op == REQ_WRITE)
                return shreg[0] ? {4'd0, w1_rel_len} : {4'd0, w0_rel_len};
            return 16'(READ_SAMPLE_TICKS + READ_RECOVERY_TICKS);
        endfunction

        // one tick of slot timing, returns 1 when the whole sequence ends
        function bit advance_tick(logic level);
            logic [15:0] len;
            logic [15:0] at;
            if (ph == SEQ_LOW) begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= low_len()) begin
                    ph       = SEQ_RELEASE;
                    tick_cnt = '0;
                end
                return 1'b0;
            end
            if (ph != SEQ_RELEASE)
                return 1'b0;
            len = rel_len();
            if (op == REQ_RESET) begin
                // offset past the release window samples on its last tick
                at = pres_ofs;
                if (len == 16'd0)
                    at = 16'd0;
                else if (at >= len)
                    at = len - 16'd1;
                if (tick_cnt == at)
                    pres = ~level;
            end else if (op == REQ_READ) begin
                if (tick_cnt == 16'(READ_SAMPLE_TICKS))
                    shreg = {level, shreg[7:1]};
            end
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt < len)
                return 1'b0;
            tick_cnt = '0;
            if (op == REQ_RESET) begin
                ph = SEQ_IDLE;
                return 1'b1;
            end
            if (op == REQ_WRITE)
                shreg = shreg >> 1;
            if (bit_no == 3'd7) begin
                bit_no = '0;
                if (op == REQ_READ)
                    rd_byte = shreg;
                ph = SEQ_IDLE;
                return 1'b1;
            end
            bit_no = bit_no + 3'd1;
            ph     = SEQ_LOW;
            return 1'b0;
        endfunction

        function void note_request(owm_in_t it);
            owm_out_t want;
            bit       done;
            bit       rej;
            done = 1'b0;
            rej  = 1'b0;
            if (it.req_type == REQ_TICK) begin
                done = advance_tick(it.bus_level);
                if (done) begin
                    if (op == REQ_RESET)
                        resets_done++;
                    else if (op == REQ_WRITE)
                        writes_done++;
                    else
                        reads_done++;
                end
            end else if (ph != SEQ_IDLE) begin
                rej = 1'b1;
                rejects_seen++;
            end else begin
                op       = it.req_type;
                ph       = SEQ_LOW;
                tick_cnt = '0;
                bit_no   = '0;
                if (op == REQ_RESET)
                    pres = 1'b0;
                shreg = (op == REQ_WRITE) ? it.write_data : 8'd0;
            end
            want.drive_low = (ph == SEQ_LOW);
            want.busy_res  = (ph != SEQ_IDLE);
            want.done_res  = done;
            want.presence  = pres;
            want.read_data = rd_byte;
            want.rejected  = rej;
            want_q.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            // keep the log short when something is badly broken
            if (errors <= MAX_REPORTS)
                $display("MISMATCH at %0t, result %0d: %s", $time, checked, msg);
        endtask

        task check_result(owm_out_t got);
            owm_out_t want;
            if (want_q.size() == 0) begin
                report($sformatf("result %0h arrived with nothing expected", got));
                return;
            end
            want = want_q.pop_front();
            if (got.drive_low !== want.drive_low)
                report($sformatf("drive_low %0b, expected %0b", got.drive_low, want.drive_low));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %0b, expected %0b", got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                report($sformatf("done_res %0b, expected %0b", got.done_res, want.done_res));
            if (got.presence !== want.presence)
                report($sformatf("presence %0b, expected %0b", got.presence, want.presence));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %0h, expected %0h", got.read_data, want.read_data));
            if (got.rejected !== want.rejected)
                report($sformatf("rejected %0b, expected %0b", got.rejected, want.rejected));
            checked++;
        endtask

        function bit busy();
            return ph != SEQ_IDLE;
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    owm_in_t               req_item  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    owm_out_t              res_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    owm_scoreboard sb;
    logic [15:0]   cfg_vals [8];
    bit            send_idle_on = 1'b1;
    bit            recv_idle_on = 1'b1;
    int            items_sent   = 0;
    int            cycles       = 0;

    one_wire_bus_master #(
        .READ_SAMPLE_TICKS   (READ_SAMPLE_TICKS),
        .READ_RECOVERY_TICKS (READ_RECOVERY_TICKS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("** one_wire_bus_master: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_item);
    end

    function int draw_gap(bit on);
        if (!on || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // result side: a random stall before each item
    initial
    begin : result_sink
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(recv_idle_on);
            if (gap > 0)
            begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
        end
    end

    task send_item(owm_in_t it);
        int gap;
        gap = draw_gap(send_idle_on);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(it);
        items_sent++;
    endtask

    task send_tick(logic level);
        owm_in_t it;
        it.req_type   = REQ_TICK;
        it.write_data = 8'($urandom);
        it.bus_level  = level;
        send_item(it);
    endtask

    task send_cmd(logic [1:0] req, logic [7:0] data);
        owm_in_t it;
        it.req_type   = req;
        it.write_data = data;
        it.bus_level  = 1'($urandom_range(0, 1));
        send_item(it);
    endtask

    // hold the request side until every result is back
    task drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function logic pick_level(level_mode_t m);
        if (m == LVL_HIGH)
            return 1'b1;
        if (m == LVL_LOW)
            return 1'b0;
        return 1'($urandom_range(0, 1));
    endfunction

    // ticks until the sequence ends, with stray commands when noisy
    task finish_sequence(level_mode_t m, bit noisy);
        while (sb.busy())
        begin
            if (noisy && $urandom_range(0, 39) == 0)
                send_cmd(2'($urandom_range(1, 3)), 8'($urandom));
            else if (noisy && $urandom_range(0, 299) == 0)
                drain();
            else
                send_tick(pick_level(m));
        end
    endtask

    task run_sequence(logic [1:0] req, logic [7:0] data, level_mode_t m, bit noisy);
        send_cmd(req, data);
        finish_sequence(m, noisy);
    endtask

    // call only when drained
    task set_timing();
        for (int i = 0; i <= int'(CFG_READ_LOW); i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= cfg_vals[i];
            @(posedge clk);
            sb.write_reg(3'(i), cfg_vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function void fill_random_timing();
        cfg_vals[CFG_RESET_LOW]     = 16'($urandom_range(0, 6));
        cfg_vals[CFG_RESET_RELEASE] = 16'($urandom_range(0, 8));
        cfg_vals[CFG_PRESENCE_OFS]  = 16'($urandom_range(0, 10));
        // upper nibble is outside the 12-bit registers and must be dropped
        cfg_vals[CFG_W1_LOW]  = {4'($urandom), 12'($urandom_range(0, 6))};
        cfg_vals[CFG_W1_HIGH] = {4'($urandom), 12'($urandom_range(0, 6))};
        cfg_vals[CFG_W0_LOW]  = {4'($urandom), 12'($urandom_range(0, 6))};
        cfg_vals[CFG_W0_HIGH] = {4'($urandom), 12'($urandom_range(0, 6))};
        cfg_vals[CFG_READ_LOW] = {4'($urandom), 12'($urandom_range(0, 6))};
    endfunction

    function void fill_default_timing();
        cfg_vals[CFG_RESET_LOW]     = 16'd3812;
        cfg_vals[CFG_RESET_RELEASE] = 16'd3897;
        cfg_vals[CFG_PRESENCE_OFS]  = 16'd0;
        cfg_vals[CFG_W1_LOW]        = 16'd40;
        cfg_vals[CFG_W1_HIGH]       = 16'd500;
        cfg_vals[CFG_W0_LOW]        = 16'd470;
        cfg_vals[CFG_W0_HIGH]       = 16'd60;
        cfg_vals[CFG_READ_LOW]      = 16'd44;
    endfunction

    // short slots, presence offset past the release window
    function void fill_short_timing();
        cfg_vals[CFG_RESET_LOW]     = 16'd2;
        cfg_vals[CFG_RESET_RELEASE] = 16'd5;
        cfg_vals[CFG_PRESENCE_OFS]  = 16'd9;
        cfg_vals[CFG_W1_LOW]        = 16'd1;
        cfg_vals[CFG_W1_HIGH]       = 16'd3;
        cfg_vals[CFG_W0_LOW]        = 16'd2;
        cfg_vals[CFG_W0_HIGH]       = 16'd1;
        cfg_vals[CFG_READ_LOW]      = 16'd1;
    endfunction

    initial
    begin
        int pick;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default timing out of reset: part of a bus reset low time, then
        // the timing is shortened mid-sequence and applies from the next tick
        send_tick(1'b1);
        send_cmd(REQ_RESET, 8'h00);
        repeat (50) send_tick(1'b1);
        drain();
        fill_short_timing();
        set_timing();
        finish_sequence(LVL_LOW, 1'b0);
        drain();

        // a write one slot runs its whole default low time, busy commands
        // are rejected, then the release is cut short
        fill_default_timing();
        set_timing();
        send_cmd(REQ_WRITE, 8'hA5);
        repeat (45) send_tick(1'($urandom_range(0, 1)));
        send_cmd(REQ_RESET, 8'h00);
        send_cmd(REQ_READ, 8'h00);
        drain();
        fill_short_timing();
        set_timing();
        finish_sequence(LVL_RANDOM, 1'b0);
        drain();

        // zero in every register acts as one tick
        for (int i = 0; i <= int'(CFG_READ_LOW); i++)
            cfg_vals[i] = 16'd0;
        set_timing();
        run_sequence(REQ_RESET, 8'h00, LVL_HIGH, 1'b0);
        run_sequence(REQ_WRITE, 8'h00, LVL_RANDOM, 1'b0);
        run_sequence(REQ_WRITE, 8'hFF, LVL_RANDOM, 1'b0);
        run_sequence(REQ_READ, 8'h00, LVL_RANDOM, 1'b0);
        drain();

        // presence offset past the release window, new reset clears presence
        fill_short_timing();
        set_timing();
        run_sequence(REQ_RESET, 8'h00, LVL_LOW, 1'b0);
        run_sequence(REQ_RESET, 8'h00, LVL_HIGH, 1'b0);
        run_sequence(REQ_WRITE, 8'h96, LVL_RANDOM, 1'b0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            send_idle_on = (p % 4 != 3);
            recv_idle_on = (p % 4 != 2);
            fill_random_timing();
            set_timing();
            for (int s = 0; s < SEQS_PER_PHASE; s++)
            begin
                // ticks while idle are ignored by the block
                repeat ($urandom_range(0, 2)) send_tick(1'($urandom_range(0, 1)));
                pick = $urandom_range(0, 2);
                if (pick == 0)
                    run_sequence(REQ_RESET, 8'($urandom), LVL_RANDOM, 1'b1);
                else
                    run_sequence(REQ_WRITE, 8'($urandom), LVL_RANDOM, 1'b1);
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));

        $display("covered %0d items and %0d results, directed timing plus %0d random settings",
                 items_sent, sb.checked, RANDOM_PHASES);
        $display("sequences: %0d resets, %0d writes, %0d reads; %0d busy commands rejected",
                 sb.resets_done, sb.writes_done, sb.reads_done, sb.rejects_seen);
        if (sb.errors == 0)
            $display("** one_wire_bus_master: PASSED **");
        else
            $display("** one_wire_bus_master: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/core/owm_pkg.sv
rtl/core/owm_cfg_regs.sv
rtl/core/owm_seq.sv
rtl/core/one_wire_bus_master.sv
rtl/core/owm_checker.sv
tb/one_wire_bus_master_tb.sv
